// File: hw/rtl/fmpm_pkg.sv
package fmpm_pkg;

   // rotation engine sizing
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
   localparam int XY_BITS      = 18;
   localparam int Z_BITS       = 34;
   localparam int ANGLE_BITS   = 32;
   localparam int OUT_BITS     = 16;

   // cordic gain 0.60725 in q1.15
   localparam logic signed [XY_BITS-1:0] CORDIC_X0 = 18'sd19898;

   // request kinds carried on tuser
   localparam logic KIND_AUDIO = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // control from the sequencer to the phase accumulator
   typedef struct packed {
      logic clear;
      logic mult;
      logic add;
   } fmpm_acc_ctrl_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic [ANGLE_BITS-1:0] atan_lookup(input logic [STEP_BITS-1:0] idx);
      logic [ANGLE_BITS-1:0] val;
      case (idx)
         4'd0:    val = 32'h2000_0000;
         4'd1:    val = 32'h12E4_051E;
         4'd2:    val = 32'h09FB_385B;
         4'd3:    val = 32'h0511_11D4;
         4'd4:    val = 32'h028B_0D43;
         4'd5:    val = 32'h0145_D7E1;
         4'd6:    val = 32'h00A2_F61E;
         4'd7:    val = 32'h0051_7C55;
         4'd8:    val = 32'h0028_BE53;
         4'd9:    val = 32'h0014_5F2F;
         4'd10:   val = 32'h000A_2F98;
         4'd11:   val = 32'h0005_17CC;
         4'd12:   val = 32'h0002_8BE6;
         4'd13:   val = 32'h0001_45F3;
         4'd14:   val = 32'h0000_A2FA;
         4'd15:   val = 32'h0000_517D;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: hw/rtl/fmpm_phase_acc.sv
module fmpm_phase_acc #(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fmpm_pkg::fmpm_acc_ctrl_type     ctrl,
   input  logic                            csr_we,
   input  logic [31:0]                     csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]   sample,
   output logic [fmpm_pkg::ANGLE_BITS-1:0] angle
);
   import fmpm_pkg::*;

   localparam int PROD_BITS = 32 + SAMPLE_BITS;
   localparam int EXT_BITS  = PHASE_BITS + PROD_BITS;

   logic signed [31:0]           sens_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic [PHASE_BITS-1:0]        phase_ff;
   logic [PHASE_BITS-1:0]        phase_in;
   logic signed [PROD_BITS-1:0]  step;
   logic signed [EXT_BITS-1:0]   step_ext;
   logic [PHASE_BITS+31:0]       phase_wide;

   // floor shift of the scaled sample, then sign extend to the phase width
   assign step     = prod_ff >>> (SAMPLE_BITS - 1);
   assign step_ext = EXT_BITS'(step);

   always_comb begin
      phase_in = phase_ff;
      if (ctrl.clear) begin
         phase_in = '0;
      end else if (ctrl.add) begin
         phase_in = phase_ff + step_ext[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= '0;
         phase_ff <= '0;
      end else begin
         if (csr_we) begin
            sens_ff <= csr_wdata;
         end
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mult) begin
         prod_ff <= sens_ff * sample;
      end
   end

   // top 32 bits of the phase, zero filled below when the phase is narrower
   assign phase_wide = {phase_ff, 32'b0};
   assign angle      = phase_wide[PHASE_BITS+31 -: ANGLE_BITS];

endmodule

// File: hw/rtl/fmpm_cordic.sv
module fmpm_cordic (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fmpm_pkg::ANGLE_BITS-1:0] angle,
   output logic                            busy,
   output logic [fmpm_pkg::OUT_BITS-1:0]   res_i,
   output logic [fmpm_pkg::OUT_BITS-1:0]   res_q
);
   import fmpm_pkg::*;

   logic                        busy_ff;
   logic                        busy_in;
   logic [STEP_BITS-1:0]        iter_ff;
   logic [STEP_BITS-1:0]        iter_in;
   logic                        flip_ff;
   logic                        flip_in;
   logic signed [XY_BITS-1:0]   x_ff;
   logic signed [XY_BITS-1:0]   x_in;
   logic signed [XY_BITS-1:0]   y_ff;
   logic signed [XY_BITS-1:0]   y_in;
   logic signed [Z_BITS-1:0]    z_ff;
   logic signed [Z_BITS-1:0]    z_in;
   logic signed [ANGLE_BITS-1:0] z_start;
   logic                        fold;
   logic signed [XY_BITS-1:0]   dx;
   logic signed [XY_BITS-1:0]   dy;
   logic signed [Z_BITS-1:0]    da;
   logic signed [XY_BITS-1:0]   x_fin;
   logic signed [XY_BITS-1:0]   y_fin;

   function automatic logic [OUT_BITS-1:0] sat16(input logic signed [XY_BITS-1:0] v);
      logic [OUT_BITS-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[OUT_BITS-1:0];
      end
      return r;
   endfunction

   // beyond a quarter turn: move by a half turn, which is a flip of the top bit
   assign fold    = ($signed(angle) > 32'sh4000_0000) || ($signed(angle) < -32'sh4000_0000);
   assign z_start = fold ? (angle ^ 32'h8000_0000) : angle;

   // shared micro-rotation
   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;
   assign da = Z_BITS'(atan_lookup(iter_ff));

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         flip_in = fold;
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = Z_BITS'(z_start);
      end else if (busy_ff) begin
         if (!z_ff[Z_BITS-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign x_fin = flip_ff ? -x_ff : x_ff;
   assign y_fin = flip_ff ? -y_ff : y_ff;
   assign busy  = busy_ff;
   assign res_i = sat16(x_fin);
   assign res_q = sat16(y_fin);

endmodule

// File: hw/rtl/fm_phase_modulator.sv
// fm phase modulator: each audio request (tuser = 0) carries a signed q1.15 sample in
// tdata; it is scaled by the sensitivity register (floor of sensitivity * sample /
// 2^(SAMPLE_BITS-1)) and added modulo 2^PHASE_BITS to the phase accumulator, and one
// response returns cos and sin of the new phase as saturated q1.15 i and q. a clear
// request (tuser = 1) zeroes the phase and gives no response. the product is formed at
// the accepting edge, and the response is offered after an accumulate, a load of the
// rotation engine, 16 cordic steps on a single shared add/shift unit and a load of
// the output register; req_tready is low until the response is loaded, so an audio
// request is not accepted before the previous response is loaded, which is later when the
// previous response still blocks the output register. a clear request leaves req_tready high.
// the next request is accepted while a response is still waiting on rsp_tready.
// csr_we/csr_wdata write the sensitivity register and should only be used while idle.
module fm_phase_modulator #(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample
   input  logic                                  req_tuser,  // kind
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [31:0]                           rsp_tdata,  // out_q, out_i
   // sensitivity register
   input  logic                                  csr_we,
   input  logic [31:0]                           csr_wdata
);
   import fmpm_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a request
   localparam logic [1:0] ST_ACC   = 2'd1;  // product ready, add step to phase
   localparam logic [1:0] ST_START = 2'd2;  // load the rotation engine
   localparam logic [1:0] ST_ROT   = 2'd3;  // rotating, then hand over the result

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [31:0]              rsp_data_ff;
   logic                     req_fire;
   logic                     slot_free;
   logic                     cordic_start;
   logic                     cordic_busy;
   logic [ANGLE_BITS-1:0]    angle;
   logic [OUT_BITS-1:0]      res_i;
   logic [OUT_BITS-1:0]      res_q;
   logic                     load_rsp;
   fmpm_acc_ctrl_type        acc_ctrl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // output register is free when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign acc_ctrl.clear = req_fire && (req_tuser == KIND_CLEAR);
   assign acc_ctrl.mult  = req_fire && (req_tuser == KIND_AUDIO);
   assign acc_ctrl.add   = (state_ff == ST_ACC);
   assign cordic_start   = (state_ff == ST_START);
   assign load_rsp       = (state_ff == ST_ROT) && !cordic_busy && slot_free;

   fmpm_phase_acc #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_phase_acc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sample    ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .angle     (angle)
   );

   fmpm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (angle),
      .busy  (cordic_busy),
      .res_i (res_i),
      .res_q (res_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_ctrl.mult) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_ROT;
         end
         ST_ROT: begin
            // engine holds its result until the output register can take it
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {res_q, res_i};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // no new request while the rotation engine is working
   a_busy_not_ready : assert property (@(posedge clock) disable iff (reset)
      cordic_busy |-> !req_tready)
      else $error("request accepted while rotation engine busy");

   // a clear request zeroes the phase on the next cycle
   a_clear_zeroes : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_CLEAR)) |=> (angle == '0))
      else $error("clear request did not zero the phase");

   // an audio request runs into the accumulate step
   a_audio_acc : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_AUDIO)) |=> (state_ff == ST_ACC))
      else $error("audio request did not start the sequence");

   // loading the engine makes it busy
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      cordic_start |=> cordic_busy)
      else $error("rotation engine did not start");

   // a pending response is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

endmodule
